FILE: rtl/thnpc_pkg.sv
// Package: shared types, widths and helper functions for the pair counter.
`default_nettype none
package thnpc_pkg;

  localparam int ROW_W   = 64;  // adjacency row width
  localparam int NODE_W  = 7;   // node count register width
  localparam int COUNT_W = 12;  // result width
  localparam int POP_W   = 7;   // popcount of one row

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_OWN,
    ST_CAP,
    ST_WALK,
    ST_SUM
  } state_t;

  // Ones in every vertex position below n.
  function automatic logic [ROW_W-1:0] vertex_mask(input logic [NODE_W-1:0] n);
    logic [ROW_W-1:0] m;
    for (int k = 0; k < ROW_W; k++) begin
      m[k] = (NODE_W'(k) < n);
    end
    return m;
  endfunction

  function automatic logic [POP_W-1:0] pop_count(input logic [ROW_W-1:0] x);
    logic [POP_W-1:0] c;
    c = '0;
    for (int k = 0; k < ROW_W; k++) begin
      c = c + POP_W'(x[k]);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/thnpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module thnpc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/two_hop_nonneighbor_pair_count_unit.sv
// Top level: loads adjacency rows into RAM and counts two-hop non-neighbor pairs.
//
// Usage:
//   Input: drive start with in_row_bits; a row transfers on a clock edge
//   with start high and busy low. Rows 0..n-1 of a matrix arrive in order,
//   n being the node_count register clamped to 1..MAX_NODES. Rows stream
//   at one per cycle while the block is loading.
//   Config: cfg_data transfers when cfg_valid and cfg_ready are high;
//   cfg_ready is high whenever the block is loading. A write restarts the
//   current matrix.
//   Result: after the last row the block goes busy and walks the stored
//   matrix: for each row i it reads row i, then every row j over the single
//   RAM read port, ORing rows of neighbors, then adds a popcount.
//   out_valid pulses for one cycle with out_pair_count in the cycle after
//   the last sum, and busy drops at the same time. The receiver cannot
//   stall; out_valid is not held beyond that cycle, while out_pair_count
//   keeps its value until the next result.
//   Reset: rst_n (synchronous) clears the row counter, sets node_count to
//   64 and returns to loading. RAM contents are not cleared; only rows
//   written in the current matrix are ever read.
`default_nettype none
module two_hop_nonneighbor_pair_count_unit
  import thnpc_pkg::*;
#(
  parameter int MAX_NODES = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [ROW_W-1:0]    in_row_bits,
  output logic                     out_valid,
  output logic      [COUNT_W-1:0]  out_pair_count,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [NODE_W-1:0]   cfg_data
);

  localparam int AW = $clog2(MAX_NODES);

  state_t state_r, state_nxt;
  logic [NODE_W-1:0]  node_count_r, node_count_nxt;
  logic [AW-1:0]      rows_loaded_r, rows_loaded_nxt;
  logic [AW-1:0]      i_r, i_nxt;
  logic [AW-1:0]      j_r, j_nxt;
  logic [ROW_W-1:0]   own_r, own_nxt;
  logic [ROW_W-1:0]   reach_r, reach_nxt;
  logic [COUNT_W-1:0] total_r, total_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  logic [NODE_W-1:0]  n_eff;
  logic [AW-1:0]      n_m1;
  logic [AW-1:0]      slot;
  logic [ROW_W-1:0]   mask;
  logic [ROW_W-1:0]   rem;
  logic [COUNT_W-1:0] sum;
  logic               in_xfer;
  logic               cfg_xfer;
  logic               ram_we;
  logic [AW-1:0]      ram_raddr;
  logic [ROW_W-1:0]   ram_rdata;

  // Effective vertex count: 0 acts as 1, anything above MAX_NODES as MAX_NODES.
  always_comb begin
    if (node_count_r == '0) begin
      n_eff = NODE_W'(1);
    end else if (node_count_r > NODE_W'(MAX_NODES)) begin
      n_eff = NODE_W'(MAX_NODES);
    end else begin
      n_eff = node_count_r;
    end
  end

  assign n_m1  = AW'(n_eff - NODE_W'(1));
  assign slot  = (rows_loaded_r >= n_m1) ? n_m1 : rows_loaded_r;
  assign mask  = vertex_mask(n_eff);
  assign rem   = reach_r & mask & ~own_r & ~(ROW_W'(1) << i_r);
  assign sum   = total_r + COUNT_W'(pop_count(rem));

  assign in_xfer  = start && !busy;
  assign cfg_xfer = cfg_valid && cfg_ready;
  assign ram_we   = in_xfer;

  thnpc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_NODES)
  ) u_adj_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (in_row_bits & mask),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state and datapath
  always_comb begin
    state_nxt       = state_r;
    node_count_nxt  = node_count_r;
    rows_loaded_nxt = rows_loaded_r;
    i_nxt           = i_r;
    j_nxt           = j_r;
    own_nxt         = own_r;
    reach_nxt       = reach_r;
    total_nxt       = total_r;
    out_valid_nxt   = 1'b0;
    out_count_nxt   = out_count_r;
    case (state_r)
      ST_LOAD: begin
        if (in_xfer) begin
          if (slot == n_m1) begin
            rows_loaded_nxt = '0;
            i_nxt           = '0;
            total_nxt       = '0;
            state_nxt       = ST_OWN;
          end else begin
            rows_loaded_nxt = slot + AW'(1);
          end
        end
        if (cfg_xfer) begin
          node_count_nxt  = cfg_data;
          rows_loaded_nxt = '0;
        end
      end
      ST_OWN: begin
        state_nxt = ST_CAP;
      end
      ST_CAP: begin
        own_nxt   = ram_rdata & mask;
        reach_nxt = '0;
        j_nxt     = '0;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        // ram_rdata holds row j_r, read last cycle
        if (own_r[6'(j_r)]) begin
          reach_nxt = reach_r | ram_rdata;
        end
        if (j_r == n_m1) begin
          state_nxt = ST_SUM;
        end else begin
          j_nxt = j_r + AW'(1);
        end
      end
      ST_SUM: begin
        total_nxt = sum;
        if (i_r == n_m1) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = sum;
          state_nxt     = ST_LOAD;
        end else begin
          i_nxt     = i_r + AW'(1);
          state_nxt = ST_OWN;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Outputs and RAM read address
  always_comb begin
    busy      = 1'b1;
    cfg_ready = 1'b0;
    ram_raddr = i_r;
    case (state_r)
      ST_LOAD: begin
        busy      = 1'b0;
        cfg_ready = 1'b1;
      end
      ST_OWN:  ram_raddr = i_r;
      ST_CAP:  ram_raddr = '0;
      ST_WALK: ram_raddr = j_r + AW'(1);
      ST_SUM:  ram_raddr = i_r;
      default: ram_raddr = i_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_LOAD;
      node_count_r  <= NODE_W'(64);
      rows_loaded_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      node_count_r  <= node_count_nxt;
      rows_loaded_r <= rows_loaded_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    own_r       <= own_nxt;
    reach_r     <= reach_nxt;
    total_r     <= total_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_pair_count = out_count_r;

endmodule
`default_nettype wire
